// File: design/drdc_pkg.sv
package drdc_pkg;

    // Field widths
    localparam int ReqTypeW = 1;
    localparam int BitRateW = 17;
    localparam int WordW    = 8;
    localparam int DivOutW  = 8;
    localparam int RateOutW = 19;

    // Divider datapath widths
    localparam int DvdW = 20;                 // dividend, also quotient width
    localparam int DsrW = 17;                 // divisor
    localparam int RemW = DsrW;               // partial remainder stays below divisor
    localparam int NumCells = DvdW;           // one quotient bit per cell

    // Rate constants
    localparam int BaseClock  = 20000000;
    localparam int BaseDiv    = 29;
    localparam int BaseRate   = BaseClock / BaseDiv;  // 689655
    localparam int PrescaleDv = 8;
    localparam int SlowRate   = BaseRate / PrescaleDv; // 86206
    localparam int RateMin    = 600;
    localparam int RateMax    = 115200;
    localparam int RateSplit  = 4800;
    localparam int PrescaleSh = 7;

    // Request codes
    localparam logic [ReqTypeW-1:0] ReqFwd = 1'b0;
    localparam logic [ReqTypeW-1:0] ReqRev = 1'b1;

    typedef struct packed {
        logic [ReqTypeW-1:0] req_type;
        logic                cs;     // prescaler select
        logic                oor;    // forward rate out of range
        logic [DsrW-1:0]     dsr;
        logic [DvdW-1:0]     dvd;    // dividend bits not yet consumed, MSB first
        logic [RemW-1:0]     rem;
        logic [DvdW-1:0]     quo;
    } t_lane;

    typedef struct packed {
        logic [DivOutW-1:0]  divider_out;
        logic [RateOutW-1:0] rate_out;
        logic                out_of_range;
    } t_res;

    // Set up dividend and divisor for either direction
    function automatic t_lane drdc_prep(
        input logic [ReqTypeW-1:0] req_type,
        input logic [BitRateW-1:0] bit_rate,
        input logic [WordW-1:0]    divider_word
    );
        t_lane l;
        logic  slow;
        logic  bad;
        l          = '0;
        l.req_type = req_type;
        if (req_type == ReqFwd) begin
            slow  = bit_rate < BitRateW'(RateSplit);
            bad   = (bit_rate < BitRateW'(RateMin)) || (bit_rate > BitRateW'(RateMax));
            l.cs  = slow;
            l.oor = bad;
            l.dvd = slow ? DvdW'(SlowRate) : DvdW'(BaseRate);
            // keep the divisor nonzero when the rate is rejected anyway
            l.dsr = bad ? DsrW'(1) : DsrW'(bit_rate);
        end else begin
            l.cs  = divider_word[PrescaleSh];
            l.oor = 1'b0;
            l.dvd = DvdW'(BaseRate);
            l.dsr = DsrW'(divider_word[PrescaleSh-1:0]) + DsrW'(1);
        end
        return l;
    endfunction

    // Turn the finished quotient into the result fields
    function automatic t_res drdc_post(input t_lane l);
        t_res             r;
        logic [DvdW-1:0]  shq;
        logic [DvdW:0]    sum;
        r   = '0;
        shq = l.cs ? (l.quo >> 3) : l.quo;
        sum = {1'b0, shq} + (DvdW+1)'(1);
        if (l.req_type == ReqFwd) begin
            if (l.oor) begin
                r.out_of_range = 1'b1;
            end else begin
                // quotient is at most 143, so half of it fits in seven bits
                r.divider_out = {l.cs, l.quo[PrescaleSh:1]};
            end
        end else begin
            r.rate_out = sum[RateOutW:1];
        end
        return r;
    endfunction

endpackage

// File: design/drdc_if.sv
interface drdc_in_if;
    import drdc_pkg::*;

    logic                valid;
    logic                ready;
    logic [ReqTypeW-1:0] req_type;
    logic [BitRateW-1:0] bit_rate;
    logic [WordW-1:0]    divider_word;

    modport source (output valid, output req_type, output bit_rate, output divider_word,
                    input ready);
    modport sink   (input valid, input req_type, input bit_rate, input divider_word,
                    output ready);
endinterface

interface drdc_out_if;
    import drdc_pkg::*;

    logic                valid;
    logic                ready;
    logic [DivOutW-1:0]  divider_out;
    logic [RateOutW-1:0] rate_out;
    logic                out_of_range;

    modport source (output valid, output divider_out, output rate_out, output out_of_range,
                    input ready);
    modport sink   (input valid, input divider_out, input rate_out, input out_of_range,
                    output ready);
endinterface

// File: design/data_rate_divider_converter_top.sv
// Data rate word converter. Each request either turns a bit rate (bits per
// second) into the 8-bit data rate word, or a data rate word back into a bit
// rate; req_type picks the direction per request. Forward: rates outside
// 600..115200 give word 0 with out_of_range set; rates below 4800 select the
// prescaler (bit 7) and the divider is floor(floor(689655/8 or 1)/rate)/2.
// Reverse: rate = (floor(floor(689655/(R+1)) / 8 or 1) + 1) / 2. Unused
// result fields read 0. Throughput is one request per clock while the output
// is not stalled; each request passes through a chain of 20 divider cells,
// each of which resolves one quotient bit of its 20-bit restoring division.
// Each cell can stall on its own, so the chain keeps taking requests while
// bubbles remain, even when a finished result waits on the output.
module data_rate_divider_converter_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    drdc_in_if.sink    i_req,
    drdc_out_if.source o_res
);
    import drdc_pkg::*;

    t_lane lane  [0:NumCells];
    logic  valid [0:NumCells];
    logic  ready [0:NumCells];
    t_res  res;

    // operands are set up on the way into the first cell
    assign lane[0]     = drdc_prep(i_req.req_type, i_req.bit_rate, i_req.divider_word);
    assign valid[0]    = i_req.valid;
    assign i_req.ready = ready[0];

    // division chain, MSB of the quotient first
    for (genvar k = 0; k < NumCells; k++) begin : g_cell
        drdc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (valid[k]),
            .i_lane  (lane[k]),
            .o_ready (ready[k]),
            .o_valid (valid[k+1]),
            .o_lane  (lane[k+1]),
            .i_ready (ready[k+1])
        );
    end

    // last cell register doubles as the output register
    assign ready[NumCells] = o_res.ready;
    assign res             = drdc_post(lane[NumCells]);

    assign o_res.valid        = valid[NumCells];
    assign o_res.divider_out  = res.divider_out;
    assign o_res.rate_out     = res.rate_out;
    assign o_res.out_of_range = res.out_of_range;

endmodule

// File: design/drdc_cell.sv
module drdc_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  drdc_pkg::t_lane  i_lane,
    output logic             o_ready,
    output logic             o_valid,
    output drdc_pkg::t_lane  o_lane,
    input  logic             i_ready
);
    import drdc_pkg::*;

    logic            r_valid;
    t_lane           r_lane;
    t_lane           n_lane;
    logic [RemW:0]   rem_sh;
    logic [RemW:0]   diff;
    logic            ge;

    // one restoring division step: bring down the next dividend bit
    assign rem_sh = {i_lane.rem, i_lane.dvd[DvdW-1]};
    assign diff   = rem_sh - {1'b0, i_lane.dsr};
    assign ge     = rem_sh >= {1'b0, i_lane.dsr};

    always_comb begin
        n_lane     = i_lane;
        n_lane.rem = ge ? diff[RemW-1:0] : rem_sh[RemW-1:0];
        n_lane.dvd = {i_lane.dvd[DvdW-2:0], 1'b0};
        n_lane.quo = {i_lane.quo[DvdW-2:0], ge};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

// File: design/drdc_chk.sv
module drdc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  i_divider_out,
    input logic [18:0] i_rate_out,
    input logic        i_out_of_range
);

    // result must hold while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // rejected rate carries no word and no rate
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_of_range |-> (i_divider_out == 8'd0) && (i_rate_out == 19'd0))
        else $error("out of range result not cleared");

    // only one direction fills a result
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_rate_out != 19'd0) |-> (i_divider_out == 8'd0) && !i_out_of_range)
        else $error("both result fields set");

    // forward divider never exceeds 71
    a_div_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_divider_out[6:0] <= 7'd71))
        else $error("divider field too large");

    // chain is empty right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result present after reset");

endmodule

bind data_rate_divider_converter_top drdc_chk u_drdc_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_divider_out  (o_res.divider_out),
    .i_rate_out     (o_res.rate_out),
    .i_out_of_range (o_res.out_of_range)
);
